// ----- design/dctcp_alpha_estimator_macros.svh -----
// assertion macros for the dctcp alpha estimator checker
// expects aclk and aresetn in the scope of use
`ifndef DCTCP_ALPHA_ESTIMATOR_MACROS_SVH
`define DCTCP_ALPHA_ESTIMATOR_MACROS_SVH

// same-cycle implication, off while in reset
`define DCTCP_AE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dctcp alpha estimator check failed");

// next-cycle implication, off while in reset
`define DCTCP_AE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dctcp alpha estimator check failed");

// next-cycle implication that also holds across reset
`define DCTCP_AE_ASSERT_RAW_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("dctcp alpha estimator reset check failed");

`endif

// ----- design/dctcp_ae_pkg.sv -----
// shared types and constants of the dctcp alpha estimator
// no dependencies
`default_nettype none

package dctcp_ae_pkg;

    typedef enum logic [1:0] {
        OP_ACK    = 2'd0,
        OP_CE     = 2'd1,
        OP_NO_CE  = 2'd2,
        OP_REDUCE = 2'd3
    } op_t;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT = 1'b1;

    localparam logic [16:0] GAIN_ONE      = 17'd65536;
    localparam logic [16:0] GAIN_RESET    = 17'd4096;
    localparam logic [15:0] SEGMENT_RESET = 16'd1448;

    typedef struct packed {
        op_t         operation;
        logic [15:0] segments_acked;
        logic        ece_marked;
        logic [31:0] last_acked_seq;
        logic [31:0] next_tx_seq;
        logic [31:0] cwnd_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] cwnd_out;
        logic [16:0] alpha_q16;
        logic        ce_state;
        logic        window_closed;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic bytes_mul;
        logic accumulate;
        logic div_init;
        logic div_step;
        logic alpha_mul;
        logic alpha_upd;
        logic red_mul;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic window_reached;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/dctcp_ae_ctrl.sv -----
// sequencing state machine of the dctcp alpha estimator
// depends on dctcp_ae_pkg
`default_nettype none

module dctcp_ae_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    input  wire dctcp_ae_pkg::op_t       s_op,
    output logic                         s_ready,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    input  wire dctcp_ae_pkg::dp_status_t status,
    output dctcp_ae_pkg::dp_cmd_t        cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_BYTES     = 9'b000000010,
        S_ACCUM     = 9'b000000100,
        S_DIV_INIT  = 9'b000001000,
        S_DIV       = 9'b000010000,
        S_ALPHA_MUL = 9'b000100000,
        S_ALPHA_UPD = 9'b001000000,
        S_RED_MUL   = 9'b010000000,
        S_EMIT      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    case (s_op)
                        dctcp_ae_pkg::OP_ACK:    state_next = S_BYTES;
                        dctcp_ae_pkg::OP_REDUCE: state_next = S_RED_MUL;
                        default:                 state_next = S_EMIT;
                    endcase
                end
            end
            S_BYTES: begin
                cmd.bytes_mul = 1'b1;
                state_next    = S_ACCUM;
            end
            S_ACCUM: begin
                cmd.accumulate = 1'b1;
                state_next     = status.window_reached ? S_DIV_INIT : S_EMIT;
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_ALPHA_MUL;
                end
            end
            S_ALPHA_MUL: begin
                cmd.alpha_mul = 1'b1;
                state_next    = S_ALPHA_UPD;
            end
            S_ALPHA_UPD: begin
                cmd.alpha_upd = 1'b1;
                state_next    = S_EMIT;
            end
            S_RED_MUL: begin
                cmd.red_mul = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/dctcp_ae_datapath.sv -----
// counters, divider, alpha update and window reduction of the dctcp alpha estimator
// depends on dctcp_ae_pkg, driven by dctcp_ae_ctrl
`default_nettype none

module dctcp_ae_datapath #(
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [dctcp_ae_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dctcp_ae_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire dctcp_ae_pkg::in_item_t               s_data,
    output dctcp_ae_pkg::out_item_t                   m_data,
    input  wire dctcp_ae_pkg::dp_cmd_t                cmd,
    output dctcp_ae_pkg::dp_status_t                  status
);

    localparam int AW       = ALPHA_FRAC_BITS + 1;
    localparam int CNT_W    = $clog2(AW);
    localparam int PROD_A_W = 17 + AW;
    localparam int PROD_R_W = 32 + AW;

    localparam logic [AW-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AW - 1);
    localparam logic [PROD_A_W:0] ALPHA_ROUND = (PROD_A_W+1)'(17'h0FFFF);
    localparam logic [PROD_R_W:0] RED_ROUND = {{(PROD_R_W+1-AW){1'b0}}, {AW{1'b1}}};

    // configuration and architectural state
    logic [16:0]   gain_reg;
    logic [15:0]   segment_reg;
    logic [31:0]   acked_reg;
    logic [31:0]   marked_reg;
    logic [31:0]   window_end_reg;
    logic [AW-1:0] alpha_reg;
    logic          ce_reg;
    logic          closed_reg;

    // working registers
    dctcp_ae_pkg::in_item_t  item_reg;
    dctcp_ae_pkg::out_item_t out_reg;
    logic [31:0]             bytes_reg;
    logic [32:0]             rem_reg;
    logic [AW-1:0]           quot_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    frac_zero_reg;
    logic                    down_reg;
    logic [PROD_A_W-1:0]     prod_a_reg;
    logic [PROD_R_W-1:0]     prod_r_reg;

    logic [32:0]       acked_sum, marked_sum;
    logic [31:0]       acked_sat, marked_sat;
    logic [31:0]       we_eff, seq_gap;
    logic              rem_ge;
    logic [32:0]       rem_sub;
    logic [AW-1:0]     frac, diff, alpha_new;
    logic [16:0]       gain_eff;
    logic              down;
    logic [PROD_A_W:0] prod_round;
    logic [PROD_R_W:0] red_sum;
    logic [32:0]       cut;
    logic [31:0]       cwnd_red;
    logic [16:0]       alpha_q16;
    logic              ce_next;

    // saturating byte counters
    assign acked_sum  = {1'b0, acked_reg} + {1'b0, bytes_reg};
    assign marked_sum = {1'b0, marked_reg} + {1'b0, bytes_reg};
    assign acked_sat  = acked_sum[32] ? 32'hFFFF_FFFF : acked_sum[31:0];
    assign marked_sat = marked_sum[32] ? 32'hFFFF_FFFF : marked_sum[31:0];

    // serial-order window end test
    assign we_eff  = (window_end_reg == 32'd0) ? item_reg.next_tx_seq : window_end_reg;
    assign seq_gap = item_reg.last_acked_seq - we_eff;
    assign status.window_reached = !seq_gap[31];

    // restoring divider, one quotient bit a cycle
    assign rem_ge  = rem_reg >= {1'b0, acked_reg};
    assign rem_sub = rem_ge ? (rem_reg - {1'b0, acked_reg}) : rem_reg;
    assign status.div_last = (cnt_reg == CNT_LAST);

    assign frac = frac_zero_reg ? '0 : ((quot_reg > ALPHA_ONE) ? ALPHA_ONE : quot_reg);

    // ewma step
    assign gain_eff   = (gain_reg > dctcp_ae_pkg::GAIN_ONE) ? dctcp_ae_pkg::GAIN_ONE : gain_reg;
    assign down       = frac < alpha_reg;
    assign diff       = down ? (alpha_reg - frac) : (frac - alpha_reg);
    assign prod_round = {1'b0, prod_a_reg} + ALPHA_ROUND;
    assign alpha_new  = down_reg ? (alpha_reg - prod_round[16 +: AW])
                                 : (alpha_reg + prod_a_reg[16 +: AW]);

    // window reduction, cut rounded up
    assign red_sum  = {1'b0, prod_r_reg} + RED_ROUND;
    assign cut      = red_sum[AW +: 33];
    assign cwnd_red = (cut >= {1'b0, item_reg.cwnd_in}) ? 32'd0
                                                        : (item_reg.cwnd_in - cut[31:0]);

    generate
        if (ALPHA_FRAC_BITS >= 16) begin : g_q16_down
            assign alpha_q16 = 17'(alpha_reg >> (ALPHA_FRAC_BITS - 16));
        end else begin : g_q16_up
            assign alpha_q16 = 17'(alpha_reg) << (16 - ALPHA_FRAC_BITS);
        end
    endgenerate

    always_comb begin
        case (item_reg.operation)
            dctcp_ae_pkg::OP_CE:    ce_next = 1'b1;
            dctcp_ae_pkg::OP_NO_CE: ce_next = 1'b0;
            default:                ce_next = ce_reg;
        endcase
    end

    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= dctcp_ae_pkg::GAIN_RESET;
            segment_reg    <= dctcp_ae_pkg::SEGMENT_RESET;
            acked_reg      <= '0;
            marked_reg     <= '0;
            window_end_reg <= '0;
            alpha_reg      <= ALPHA_ONE;
            ce_reg         <= 1'b0;
            closed_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    dctcp_ae_pkg::CFG_GAIN:    gain_reg    <= cfg_wr_data;
                    dctcp_ae_pkg::CFG_SEGMENT: segment_reg <= cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.capture) begin
                closed_reg <= 1'b0;
            end
            if (cmd.accumulate) begin
                acked_reg      <= acked_sat;
                window_end_reg <= we_eff;
                closed_reg     <= status.window_reached;
                if (item_reg.ece_marked) begin
                    marked_reg <= marked_sat;
                end
            end
            if (cmd.alpha_upd) begin
                alpha_reg      <= alpha_new;
                window_end_reg <= item_reg.next_tx_seq;
                acked_reg      <= '0;
                marked_reg     <= '0;
            end
            if (cmd.emit) begin
                ce_reg <= ce_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.bytes_mul) begin
            bytes_reg <= 32'(item_reg.segments_acked) * 32'(segment_reg);
        end
        if (cmd.div_init) begin
            rem_reg       <= {1'b0, marked_reg};
            quot_reg      <= '0;
            cnt_reg       <= '0;
            frac_zero_reg <= (marked_reg == 32'd0) || (acked_reg == 32'd0);
        end
        if (cmd.div_step) begin
            rem_reg  <= {rem_sub[31:0], 1'b0};
            quot_reg <= {quot_reg[AW-2:0], rem_ge};
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        if (cmd.alpha_mul) begin
            prod_a_reg <= PROD_A_W'(gain_eff) * PROD_A_W'(diff);
            down_reg   <= down;
        end
        if (cmd.red_mul) begin
            prod_r_reg <= PROD_R_W'(item_reg.cwnd_in) * PROD_R_W'(alpha_reg);
        end
        if (cmd.emit) begin
            out_reg.cwnd_out      <= (item_reg.operation == dctcp_ae_pkg::OP_REDUCE)
                                     ? cwnd_red : item_reg.cwnd_in;
            out_reg.alpha_q16     <= alpha_q16;
            out_reg.ce_state      <= ce_next;
            out_reg.window_closed <= closed_reg;
        end
    end

endmodule

`default_nettype wire

// ----- design/dctcp_alpha_estimator.sv -----
// top level of the dctcp alpha estimator: controller plus datapath
// depends on dctcp_ae_pkg, dctcp_ae_ctrl, dctcp_ae_datapath
`default_nettype none

// DCTCP sender estimator. Each request on the s_ channel is one operation: an ack
// adds segments_acked * segment_bytes to the acked byte count (and to the marked
// count when ece_marked is set), loads an unset window end from next_tx_seq and,
// once last_acked_seq reaches the window end, folds the marked fraction into alpha
// with gain gain_q16, re-arms the window and clears the counters; a reduce request
// returns floor(cwnd_in * (1 - alpha/2)); ce / no-ce requests set or clear the echo
// state. Every request yields exactly one result request on the m_ channel. Requests
// are worked one at a time: an ack that keeps the window open passes the byte
// multiply, accumulate and emit states, a reduce the reduction multiply and emit
// states, and a ce change goes straight to emit; an ack that closes a window also
// runs divider init, the restoring divider that forms the marked fraction one
// quotient bit a cycle, then the alpha multiply and update. A finished result sits
// in an output register, so the next request is accepted while the previous result
// still waits for m_ready. Configuration writes are taken at any edge with cfg_wr_en
// high and should only be issued while the block is idle.

module dctcp_alpha_estimator #(
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [dctcp_ae_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dctcp_ae_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // operation requests
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire dctcp_ae_pkg::in_item_t               s_data,
    // result requests
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output dctcp_ae_pkg::out_item_t                   m_data
);

    // command and status between the sequencer and the datapath
    dctcp_ae_pkg::dp_cmd_t    cmd;
    dctcp_ae_pkg::dp_status_t status;

    // sequencer: owns the request handshakes and the output valid flag
    dctcp_ae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.operation),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: counters, window tracking, divider, ewma and reduction
    dctcp_ae_datapath #(
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire

// ----- design/dctcp_ae_checker.sv -----
// port-level checks of the dctcp alpha estimator, bound to the top level
// depends on dctcp_ae_pkg and dctcp_alpha_estimator_macros.svh
`default_nettype none

`include "dctcp_alpha_estimator_macros.svh"

module dctcp_ae_checker (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_valid,
    input wire logic                    s_ready,
    input wire dctcp_ae_pkg::in_item_t  s_data,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire dctcp_ae_pkg::out_item_t m_data
);

    // a waiting request holds
    `DCTCP_AE_ASSERT_NXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_data))

    // a stalled result holds
    `DCTCP_AE_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // one request in work at a time: ready drops after an accept
    `DCTCP_AE_ASSERT_NXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // alpha never exceeds one
    `DCTCP_AE_ASSERT_IMP(a_alpha_range, m_valid, m_data.alpha_q16 <= 17'd65536)

    // reset leaves no result pending
    `DCTCP_AE_ASSERT_RAW_NXT(a_reset_empty, !aresetn, !m_valid)

endmodule

bind dctcp_alpha_estimator dctcp_ae_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
